FILE: hdl/ctbc_pkg.sv
// Package for the computed-torque base controller: shared types, constants,
// register indexes and fixed-point helper functions.
// Depends on nothing; every other file of the block imports it.
package ctbc_pkg;

	// Default number of fractional bits of every Q value.
	localparam int FRAC_BITS_DEF = 16;

	// Data widths of the ports and of the exact products.
	localparam int DATA_W = 32;
	localparam int PROD_W = 64;
	localparam int IDX_W  = 4;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_KP_11 = 4'd0,
		REG_KP_12 = 4'd1,
		REG_KP_21 = 4'd2,
		REG_KP_22 = 4'd3,
		REG_KV_11 = 4'd4,
		REG_KV_12 = 4'd5,
		REG_KV_21 = 4'd6,
		REG_KV_22 = 4'd7
	} reg_idx_t;

	// A saturated value together with its clip indication.
	typedef struct packed {
		logic signed [DATA_W-1:0] val;
		logic                     clip;
	} sat_t;

	// What one axis lane hands to the merging stage.
	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic                     clip;
	} lane_out_t;

	// Build-time physical coefficients, rounded half up to the Q format.
	function automatic logic signed [DATA_W-1:0] cst_jb(int frac);
		longint v;
		v = ((64'sd5048709708 <<< frac) + 64'sd5000000000) / 64'sd10000000000;
		return DATA_W'(v);
	endfunction

	function automatic logic signed [DATA_W-1:0] cst_mb(int frac);
		longint v;
		v = 64'sd12 <<< frac;
		return DATA_W'(v);
	endfunction

	function automatic logic signed [DATA_W-1:0] cst_ua(int frac);
		longint v;
		v = ((64'sd76 <<< frac) + 64'sd500) / 64'sd1000;
		return DATA_W'(v);
	endfunction

	function automatic logic signed [DATA_W-1:0] cst_ul(int frac);
		longint v;
		v = ((64'sd19 <<< frac) + 64'sd500) / 64'sd1000;
		return DATA_W'(v);
	endfunction

	function automatic logic signed [DATA_W-1:0] cst_bi11(int frac);
		longint v;
		v = ((64'sd111 <<< frac) + 64'sd248) / 64'sd497;
		return DATA_W'(v);
	endfunction

	function automatic logic signed [DATA_W-1:0] cst_bi12(int frac);
		longint v;
		v = ((64'sd111 <<< frac) + 64'sd500) / 64'sd1000;
		return DATA_W'(v);
	endfunction

	// Rescale an exact product: add half an LSB, then arithmetic shift (floor).
	function automatic logic signed [PROD_W-1:0] qround(logic signed [PROD_W-1:0] p,
			int frac);
		logic signed [PROD_W-1:0] half;
		half = 64'sd1 <<< (frac - 1);
		return (p + half) >>> frac;
	endfunction

	// Clamp a wide value to the signed 32-bit range.
	function automatic sat_t sat32(logic signed [PROD_W-1:0] v);
		sat_t r;
		if (v > 64'sd2147483647) begin
			r.val  = 32'sh7FFF_FFFF;
			r.clip = 1'b1;
		end else if (v < -64'sd2147483648) begin
			r.val  = 32'sh8000_0000;
			r.clip = 1'b1;
		end else begin
			r.val  = v[DATA_W-1:0];
			r.clip = 1'b0;
		end
		return r;
	endfunction

endpackage

FILE: hdl/ctbc_lane.sv
// One axis lane: corrected acceleration u and generalized force x for one row.
// Depends on ctbc_pkg; instantiated twice by the top level.
module ctbc_lane #(
	parameter int FRAC_BITS = ctbc_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    aref,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    vel,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    verr_1,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    verr_2,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    perr_1,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    perr_2,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    kv_1,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    kv_2,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    kp_1,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    kp_2,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    m_coef,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    c_coef,
	output ctbc_pkg::lane_out_t                   result
);
	import ctbc_pkg::*;

	logic signed [PROD_W-1:0] pv1_s1, pv2_s1, pp1_s1, pp2_s1;
	logic signed [DATA_W-1:0] aref_s1, vel_s1, vel_s2, vel_s3;
	logic signed [PROD_W-1:0] acc_s2;
	logic signed [DATA_W-1:0] u_s3;
	logic                     clip_s3, clip_s4;
	logic signed [PROD_W-1:0] pm_s4, pc_s4;
	sat_t                     u_sat, x_sat;
	logic signed [PROD_W-1:0] acc_sum, x_sum;
	lane_out_t                x_s5;

	// Stage 1: the four gain products of this row.
	always_ff @(posedge clk) begin
		pv1_s1  <= kv_1 * verr_1;
		pv2_s1  <= kv_2 * verr_2;
		pp1_s1  <= kp_1 * perr_1;
		pp2_s1  <= kp_2 * perr_2;
		aref_s1 <= aref;
		vel_s1  <= vel;
	end

	// Stage 2: rescale the products and accumulate onto the reference.
	assign acc_sum = PROD_W'(aref_s1) + qround(pv1_s1, FRAC_BITS)
		+ qround(pv2_s1, FRAC_BITS) + qround(pp1_s1, FRAC_BITS)
		+ qround(pp2_s1, FRAC_BITS);

	always_ff @(posedge clk) begin
		acc_s2 <= acc_sum;
		vel_s2 <= vel_s1;
	end

	// Stage 3: clamp u to 32 bits.
	assign u_sat = sat32(acc_s2);

	always_ff @(posedge clk) begin
		u_s3    <= u_sat.val;
		clip_s3 <= u_sat.clip;
		vel_s3  <= vel_s2;
	end

	// Stage 4: inertia and friction products.
	always_ff @(posedge clk) begin
		pm_s4   <= m_coef * u_s3;
		pc_s4   <= c_coef * vel_s3;
		clip_s4 <= clip_s3;
	end

	// Stage 5: x = M*u + C*v, clamped.
	assign x_sum = qround(pm_s4, FRAC_BITS) + qround(pc_s4, FRAC_BITS);
	assign x_sat = sat32(x_sum);

	always_ff @(posedge clk) begin
		x_s5.x    <= x_sat.val;
		x_s5.clip <= clip_s4 | x_sat.clip;
	end

	assign result = x_s5;

endmodule

FILE: hdl/ctbc_merge.sv
// Merging stage: applies the inverse actuator matrix to both lanes' x values
// and forms the saturated wheel torques. Depends on ctbc_pkg.
module ctbc_merge #(
	parameter int FRAC_BITS = ctbc_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  ctbc_pkg::lane_out_t                   lane_a,
	input  ctbc_pkg::lane_out_t                   lane_b,
	output logic signed [ctbc_pkg::DATA_W-1:0]    tau_1,
	output logic signed [ctbc_pkg::DATA_W-1:0]    tau_2,
	output logic                                  clip
);
	import ctbc_pkg::*;

	// The lower-left entry is the exact negation of the rounded upper-left one.
	localparam logic signed [DATA_W-1:0] C_BI11 = cst_bi11(FRAC_BITS);
	localparam logic signed [DATA_W-1:0] C_BI12 = cst_bi12(FRAC_BITS);
	localparam logic signed [DATA_W-1:0] C_BI21 = -C_BI11;
	localparam logic signed [DATA_W-1:0] C_BI22 = C_BI12;

	logic signed [PROD_W-1:0] p11_s6, p12_s6, p21_s6, p22_s6;
	logic                     clip_s6;
	logic signed [PROD_W-1:0] sum_1, sum_2;
	sat_t                     t1_sat, t2_sat;
	logic signed [DATA_W-1:0] tau_1_s7, tau_2_s7;
	logic                     clip_s7;

	// Stage 6: four mixing products across the two lanes.
	always_ff @(posedge clk) begin
		p11_s6  <= C_BI11 * lane_a.x;
		p12_s6  <= C_BI12 * lane_b.x;
		p21_s6  <= C_BI21 * lane_a.x;
		p22_s6  <= C_BI22 * lane_b.x;
		clip_s6 <= lane_a.clip | lane_b.clip;
	end

	// Stage 7: rescale, add per row and clamp.
	assign sum_1  = qround(p11_s6, FRAC_BITS) + qround(p12_s6, FRAC_BITS);
	assign sum_2  = qround(p21_s6, FRAC_BITS) + qround(p22_s6, FRAC_BITS);
	assign t1_sat = sat32(sum_1);
	assign t2_sat = sat32(sum_2);

	always_ff @(posedge clk) begin
		tau_1_s7 <= t1_sat.val;
		tau_2_s7 <= t2_sat.val;
		clip_s7  <= clip_s6 | t1_sat.clip | t2_sat.clip;
	end

	assign tau_1 = tau_1_s7;
	assign tau_2 = tau_2_s7;
	assign clip  = clip_s7;

endmodule

FILE: hdl/computed_torque_base_control_unit.sv
// Computed-torque controller for a two-wheel base: gain registers, two axis
// lanes and the mixing stage. Depends on ctbc_pkg, ctbc_lane and ctbc_merge.
//
// Usage:
// - Gains are written through cfg_we / cfg_index / cfg_data, one per write;
//   indexes 0 to 3 are Kp (row-major), 4 to 7 are Kv, higher indexes are
//   dropped. Write them only while no sample is in flight.
// - A sample transfer happens at a rising edge with start high and busy low.
//   busy is always low, so a new sample may be started in every cycle.
// - Each sample yields one result: torque_right, torque_left and saturated,
//   shown for exactly one cycle with done high once the sample has left the
//   pipeline. Throughput is one sample per cycle.
// - The pipeline stages, in order: gain products, accumulate, clamp u,
//   inertia/friction products, clamp x, mixing products, clamp torque.
// - The receiver cannot stall; results are not held.
// - Reset clears the gains to zero and empties the pipeline, so no done
//   strobe follows reset until a new sample is started.
module computed_torque_base_control_unit #(
	parameter int FRAC_BITS = ctbc_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ctbc_pkg::IDX_W-1:0]            cfg_index,
	input  logic [ctbc_pkg::DATA_W-1:0]           cfg_data,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    accel_ref_lin,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    accel_ref_ang,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    pos_err_lin,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    pos_err_ang,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    vel_err_lin,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    vel_err_ang,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    meas_vel_lin,
	input  logic signed [ctbc_pkg::DATA_W-1:0]    meas_vel_ang,
	output logic                                  done,
	output logic signed [ctbc_pkg::DATA_W-1:0]    torque_right,
	output logic signed [ctbc_pkg::DATA_W-1:0]    torque_left,
	output logic                                  saturated
);
	import ctbc_pkg::*;

	localparam int PIPE_DEPTH = 7;

	localparam logic signed [DATA_W-1:0] C_JB = cst_jb(FRAC_BITS);
	localparam logic signed [DATA_W-1:0] C_MB = cst_mb(FRAC_BITS);
	localparam logic signed [DATA_W-1:0] C_UA = cst_ua(FRAC_BITS);
	localparam logic signed [DATA_W-1:0] C_UL = cst_ul(FRAC_BITS);

	logic signed [DATA_W-1:0] kp_11_q, kp_12_q, kp_21_q, kp_22_q;
	logic signed [DATA_W-1:0] kv_11_q, kv_12_q, kv_21_q, kv_22_q;
	logic [PIPE_DEPTH-1:0]    valid_pipe_q;
	logic                     accept;
	lane_out_t                lane_lin, lane_ang;
	logic signed [DATA_W-1:0] tau_1, tau_2;
	logic                     clip;

	// Every cycle can take a sample.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Gain register file; writes beyond the eight registers are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_11_q <= '0;
			kp_12_q <= '0;
			kp_21_q <= '0;
			kp_22_q <= '0;
			kv_11_q <= '0;
			kv_12_q <= '0;
			kv_21_q <= '0;
			kv_22_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KP_11: kp_11_q <= cfg_data;
				REG_KP_12: kp_12_q <= cfg_data;
				REG_KP_21: kp_21_q <= cfg_data;
				REG_KP_22: kp_22_q <= cfg_data;
				REG_KV_11: kv_11_q <= cfg_data;
				REG_KV_12: kv_12_q <= cfg_data;
				REG_KV_21: kv_21_q <= cfg_data;
				REG_KV_22: kv_22_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bits that travel alongside the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_pipe_q <= '0;
		end else begin
			valid_pipe_q <= {valid_pipe_q[PIPE_DEPTH-2:0], accept};
		end
	end

	// Linear axis lane: first row, with inertia Jb and friction ua.
	ctbc_lane #(
		.FRAC_BITS(FRAC_BITS)
	) u_lane_lin (
		.clk    (clk),
		.aref   (accel_ref_lin),
		.vel    (meas_vel_lin),
		.verr_1 (vel_err_lin),
		.verr_2 (vel_err_ang),
		.perr_1 (pos_err_lin),
		.perr_2 (pos_err_ang),
		.kv_1   (kv_11_q),
		.kv_2   (kv_12_q),
		.kp_1   (kp_11_q),
		.kp_2   (kp_12_q),
		.m_coef (C_JB),
		.c_coef (C_UA),
		.result (lane_lin)
	);

	// Second row: uses the body mass and the linear friction coefficient.
	ctbc_lane #(
		.FRAC_BITS(FRAC_BITS)
	) u_lane_ang (
		.clk    (clk),
		.aref   (accel_ref_ang),
		.vel    (meas_vel_ang),
		.verr_1 (vel_err_lin),
		.verr_2 (vel_err_ang),
		.perr_1 (pos_err_lin),
		.perr_2 (pos_err_ang),
		.kv_1   (kv_21_q),
		.kv_2   (kv_22_q),
		.kp_1   (kp_21_q),
		.kp_2   (kp_22_q),
		.m_coef (C_MB),
		.c_coef (C_UL),
		.result (lane_ang)
	);

	// Mix both rows into the wheel torques.
	ctbc_merge #(
		.FRAC_BITS(FRAC_BITS)
	) u_merge (
		.clk    (clk),
		.lane_a (lane_lin),
		.lane_b (lane_ang),
		.tau_1  (tau_1),
		.tau_2  (tau_2),
		.clip   (clip)
	);

	assign done         = valid_pipe_q[PIPE_DEPTH-1];
	assign torque_right = tau_1;
	assign torque_left  = tau_2;
	assign saturated    = clip & done;

	// A result strobe always traces back to an earlier sample transfer that has run through the pipeline.
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_DEPTH))
		else $error("result without matching sample transfer");

	// The clip flag is only shown together with a result.
	a_sat_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !saturated)
		else $error("saturated flag outside a result cycle");

	// Every sample transfer produces a result after the pipeline latency.
	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && $past(arst_n, PIPE_DEPTH)) |-> ##PIPE_DEPTH done)
		else $error("sample transfer produced no result");

endmodule

FILE: dv/computed_torque_base_control_unit_tb.sv
// Self-checking testbench for the computed-torque base controller: a directed
// table of samples and gain settings, then random phases, all scored on the fly.
// Depends on ctbc_pkg and computed_torque_base_control_unit.
module computed_torque_base_control_unit_tb;
	import ctbc_pkg::*;

	localparam int FRAC        = FRAC_BITS_DEF;
	localparam int NUM_REGS    = int'(REG_KV_22) + 1;
	localparam int NUM_SETS    = 6;
	localparam int RAND_SET    = 5;
	localparam int NUM_PHASES  = 10;
	localparam int PHASE_ITEMS = 63;
	localparam int TAIL_CYCLES = 16;

	localparam logic signed [DATA_W-1:0] Q_MAX    = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN    = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] Q_ONE    = 32'sh0001_0000;
	localparam logic signed [DATA_W-1:0] HALF_LSB = 32'sd32768;

	localparam longint S32_HI = 64'sd2147483647;
	localparam longint S32_LO = -64'sd2147483648;

	// One control sample as it appears on the input ports.
	typedef struct packed {
		logic signed [DATA_W-1:0] accel_ref_lin;
		logic signed [DATA_W-1:0] accel_ref_ang;
		logic signed [DATA_W-1:0] pos_err_lin;
		logic signed [DATA_W-1:0] pos_err_ang;
		logic signed [DATA_W-1:0] vel_err_lin;
		logic signed [DATA_W-1:0] vel_err_ang;
		logic signed [DATA_W-1:0] meas_vel_lin;
		logic signed [DATA_W-1:0] meas_vel_ang;
	} sample_t;

	// One wheel torque result.
	typedef struct packed {
		logic signed [DATA_W-1:0] torque_right;
		logic signed [DATA_W-1:0] torque_left;
		logic                     saturated;
	} torque_t;

	// One row of the directed table.
	typedef struct packed {
		logic [2:0] gsel;
		sample_t    smp;
		logic       pinned;
		torque_t    res;
	} dir_row_t;

	// round(num / den) in the Q format, halves up.
	function automatic longint q_const(longint num, longint den);
		return ((num <<< FRAC) + den / 2) / den;
	endfunction

	localparam longint C_JB   = q_const(64'sd5048709708, 64'sd10000000000);
	localparam longint C_MB   = q_const(64'sd12, 64'sd1);
	localparam longint C_UA   = q_const(64'sd76, 64'sd1000);
	localparam longint C_UL   = q_const(64'sd19, 64'sd1000);
	localparam longint C_BI11 = q_const(64'sd111, 64'sd497);
	localparam longint C_BI12 = q_const(64'sd111, 64'sd1000);

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [IDX_W-1:0]         cfg_index = '0;
	logic [DATA_W-1:0]        cfg_data = '0;
	logic                     start = 1'b0;
	logic                     busy;
	logic signed [DATA_W-1:0] accel_ref_lin = '0;
	logic signed [DATA_W-1:0] accel_ref_ang = '0;
	logic signed [DATA_W-1:0] pos_err_lin = '0;
	logic signed [DATA_W-1:0] pos_err_ang = '0;
	logic signed [DATA_W-1:0] vel_err_lin = '0;
	logic signed [DATA_W-1:0] vel_err_ang = '0;
	logic signed [DATA_W-1:0] meas_vel_lin = '0;
	logic signed [DATA_W-1:0] meas_vel_ang = '0;
	logic                     done;
	logic signed [DATA_W-1:0] torque_right;
	logic signed [DATA_W-1:0] torque_left;
	logic                     saturated;

	// Typed-in expectation that travels with a sample.
	logic    pin_on = 1'b0;
	torque_t pin_res = '0;

	// Shadow copy of the gain registers, and the scoreboard.
	logic signed [DATA_W-1:0] kp_gain [2][2];
	logic signed [DATA_W-1:0] kv_gain [2][2];
	logic signed [DATA_W-1:0] gain_sets [NUM_SETS][NUM_REGS];
	torque_t                  torque_due [$];
	dir_row_t                 dir_q [$];
	int                       fault_count = 0;
	int                       burst_left;

	computed_torque_base_control_unit #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.accel_ref_lin(accel_ref_lin),
		.accel_ref_ang(accel_ref_ang),
		.pos_err_lin(pos_err_lin),
		.pos_err_ang(pos_err_ang),
		.vel_err_lin(vel_err_lin),
		.vel_err_ang(vel_err_ang),
		.meas_vel_lin(meas_vel_lin),
		.meas_vel_ang(meas_vel_ang),
		.done(done),
		.torque_right(torque_right),
		.torque_left(torque_left),
		.saturated(saturated)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit, far above the slowest legal run.
	initial begin
		#1_000_000;
		$display("computed_torque_base_control_unit: mismatch");
		$finish;
	end

	// Exact product rescaled with round half up.
	function automatic longint q_mul(longint a, longint b);
		return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
	endfunction

	// Clamp to the signed 32-bit range; the top bit tells whether it clipped.
	function automatic logic [DATA_W:0] clamp_s32(longint v);
		if (v > S32_HI)
			return {1'b1, Q_MAX};
		if (v < S32_LO)
			return {1'b1, Q_MIN};
		return {1'b0, v[DATA_W-1:0]};
	endfunction

	function automatic sample_t mk_sample(
		logic signed [DATA_W-1:0] a_lin, logic signed [DATA_W-1:0] a_ang,
		logic signed [DATA_W-1:0] p_lin, logic signed [DATA_W-1:0] p_ang,
		logic signed [DATA_W-1:0] v_lin, logic signed [DATA_W-1:0] v_ang,
		logic signed [DATA_W-1:0] m_lin, logic signed [DATA_W-1:0] m_ang);
		sample_t s;
		s.accel_ref_lin = a_lin;
		s.accel_ref_ang = a_ang;
		s.pos_err_lin   = p_lin;
		s.pos_err_ang   = p_ang;
		s.vel_err_lin   = v_lin;
		s.vel_err_ang   = v_ang;
		s.meas_vel_lin  = m_lin;
		s.meas_vel_ang  = m_ang;
		return s;
	endfunction

	// Wheel torques for one sample under the current gains.
	function automatic torque_t predict_torque(sample_t s);
		longint        u_lin, u_ang, x_lin, x_ang, t_r, t_l;
		logic [DATA_W:0] c;
		logic          hit;
		torque_t       r;
		hit = 1'b0;
		// Corrected acceleration, one row per axis.
		u_lin = $signed(s.accel_ref_lin)
			+ q_mul(kv_gain[0][0], $signed(s.vel_err_lin))
			+ q_mul(kv_gain[0][1], $signed(s.vel_err_ang))
			+ q_mul(kp_gain[0][0], $signed(s.pos_err_lin))
			+ q_mul(kp_gain[0][1], $signed(s.pos_err_ang));
		u_ang = $signed(s.accel_ref_ang)
			+ q_mul(kv_gain[1][0], $signed(s.vel_err_lin))
			+ q_mul(kv_gain[1][1], $signed(s.vel_err_ang))
			+ q_mul(kp_gain[1][0], $signed(s.pos_err_lin))
			+ q_mul(kp_gain[1][1], $signed(s.pos_err_ang));
		c = clamp_s32(u_lin);
		hit |= c[DATA_W];
		u_lin = $signed(c[DATA_W-1:0]);
		c = clamp_s32(u_ang);
		hit |= c[DATA_W];
		u_ang = $signed(c[DATA_W-1:0]);
		// Inertia and friction terms.
		x_lin = q_mul(C_JB, u_lin) + q_mul(C_UA, $signed(s.meas_vel_lin));
		x_ang = q_mul(C_MB, u_ang) + q_mul(C_UL, $signed(s.meas_vel_ang));
		c = clamp_s32(x_lin);
		hit |= c[DATA_W];
		x_lin = $signed(c[DATA_W-1:0]);
		c = clamp_s32(x_ang);
		hit |= c[DATA_W];
		x_ang = $signed(c[DATA_W-1:0]);
		// Mix through the inverse actuator matrix.
		t_r = q_mul(C_BI11, x_lin) + q_mul(C_BI12, x_ang);
		t_l = q_mul(-C_BI11, x_lin) + q_mul(C_BI12, x_ang);
		c = clamp_s32(t_r);
		hit |= c[DATA_W];
		r.torque_right = c[DATA_W-1:0];
		c = clamp_s32(t_l);
		hit |= c[DATA_W];
		r.torque_left = c[DATA_W-1:0];
		r.saturated = hit;
		return r;
	endfunction

	// Register writes, sample transfers and result checks, all at the edge.
	always @(posedge clk) begin : score_p
		torque_t got;
		torque_t want;
		if (cfg_we && cfg_index < NUM_REGS) begin
			if (cfg_index < REG_KV_11)
				kp_gain[cfg_index[1]][cfg_index[0]] = cfg_data;
			else
				kv_gain[cfg_index[1]][cfg_index[0]] = cfg_data;
		end
		if (start && !busy) begin
			if (pin_on)
				torque_due.push_back(pin_res);
			else
				torque_due.push_back(predict_torque(mk_sample(accel_ref_lin,
					accel_ref_ang, pos_err_lin, pos_err_ang, vel_err_lin,
					vel_err_ang, meas_vel_lin, meas_vel_ang)));
		end
		if (done) begin
			if (torque_due.size() == 0) begin
				$error("done strobe with no result outstanding");
				fault_count++;
			end else begin
				want = torque_due.pop_front();
				got.torque_right = torque_right;
				got.torque_left  = torque_left;
				got.saturated    = saturated;
				if (got.torque_right !== want.torque_right) begin
					$error("torque_right: expected %0d, got %0d",
						$signed(want.torque_right), $signed(got.torque_right));
					fault_count++;
				end
				if (got.torque_left !== want.torque_left) begin
					$error("torque_left: expected %0d, got %0d",
						$signed(want.torque_left), $signed(got.torque_left));
					fault_count++;
				end
				if (got.saturated !== want.saturated) begin
					$error("saturated: expected %0d, got %0d",
						want.saturated, got.saturated);
					fault_count++;
				end
			end
		end
	end

	task automatic add_row(logic [2:0] gsel, sample_t s, logic pin, torque_t r);
		dir_row_t row;
		row.gsel   = gsel;
		row.smp    = s;
		row.pinned = pin;
		row.res    = r;
		dir_q.push_back(row);
	endtask

	// Present one sample and wait for its transfer; bursts end in a gap.
	task automatic send_sample(sample_t s, logic pin, torque_t pr);
		accel_ref_lin <= s.accel_ref_lin;
		accel_ref_ang <= s.accel_ref_ang;
		pos_err_lin   <= s.pos_err_lin;
		pos_err_ang   <= s.pos_err_ang;
		vel_err_lin   <= s.vel_err_lin;
		vel_err_ang   <= s.vel_err_ang;
		meas_vel_lin  <= s.meas_vel_lin;
		meas_vel_ang  <= s.meas_vel_ang;
		pin_on        <= pin;
		pin_res       <= pr;
		start         <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
			if ($urandom_range(0, 5) == 0)
				burst_left = $urandom_range(40, 90);
			else
				burst_left = $urandom_range(1, 12);
		end
	endtask

	// Stop sending and let every outstanding result arrive.
	task automatic wait_idle();
		if (start) begin
			start <= 1'b0;
			@(posedge clk);
		end
		while (torque_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= IDX_W'(idx);
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// All eight gains, then one write to an unused index that must be dropped.
	task automatic load_gain_set(int k);
		for (int i = 0; i < NUM_REGS; i++)
			write_reg(i, gain_sets[k][i]);
		write_reg(NUM_REGS + $urandom_range(0, 7), $urandom);
		cfg_we <= 1'b0;
	endtask

	// Mostly moderate values, some full-range words, some extremes.
	function automatic logic signed [DATA_W-1:0] rand_q();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			case ($urandom_range(0, 4))
				0: return Q_MAX;
				1: return Q_MIN;
				2: return '0;
				3: return 32'sd1;
				default: return -32'sd1;
			endcase
		end
		if (pick <= 2)
			return $urandom;
		return int'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
	endfunction

	// Gain draw: small gains, full-range words or extremes.
	function automatic logic signed [DATA_W-1:0] rand_gain(int mode);
		if (mode == 0)
			return int'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
		if (mode == 1)
			return $urandom;
		case ($urandom_range(0, 4))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return 32'sd1;
			default: return Q_ONE;
		endcase
	endfunction

	initial begin
		int cur_set;
		int mode;
		for (int i = 0; i < 2; i++)
			for (int j = 0; j < 2; j++) begin
				kp_gain[i][j] = '0;
				kv_gain[i][j] = '0;
			end

		// Gain settings of the directed part.
		for (int i = 0; i < NUM_REGS; i++) begin
			gain_sets[0][i] = '0;
			gain_sets[1][i] = Q_MAX;
			gain_sets[2][i] = Q_MIN;
			gain_sets[3][i] = 32'sd1;
			gain_sets[4][i] = -HALF_LSB;
			gain_sets[RAND_SET][i] = '0;
		end
		gain_sets[4][REG_KP_11] = Q_ONE;
		gain_sets[4][REG_KP_22] = Q_ONE;
		gain_sets[4][REG_KV_11] = 2 * Q_ONE;
		gain_sets[4][REG_KV_22] = 2 * Q_ONE;

		// Zero gains after reset: the all-zero sample gives zero torque.
		add_row(0, mk_sample(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0);
		add_row(0, mk_sample(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX),
			1'b0, '0);
		add_row(0, mk_sample(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN),
			1'b0, '0);
		add_row(0, mk_sample(Q_MAX, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
		add_row(0, mk_sample(0, Q_MAX, 0, 0, 0, 0, 0, 0), 1'b0, '0);
		add_row(0, mk_sample(0, Q_MIN, 0, 0, 0, 0, 0, 0), 1'b0, '0);
		add_row(0, mk_sample(0, 0, 0, 0, 0, 0, Q_MAX, Q_MIN), 1'b0, '0);
		add_row(0, mk_sample(Q_ONE, Q_ONE, 0, 0, 0, 0, Q_ONE, -Q_ONE), 1'b0, '0);
		// Largest gains: zero errors still give zero, full errors clip u.
		add_row(1, mk_sample(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0);
		add_row(1, mk_sample(0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 0), 1'b0, '0);
		add_row(1, mk_sample(0, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0), 1'b0, '0);
		add_row(1, mk_sample(Q_ONE, -Q_ONE, Q_MIN, Q_MIN, Q_MAX, Q_MAX, 0, 0),
			1'b0, '0);
		// Most negative gains.
		add_row(2, mk_sample(0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX),
			1'b0, '0);
		add_row(2, mk_sample(0, 0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN),
			1'b0, '0);
		add_row(2, mk_sample(Q_MIN, Q_MAX, Q_ONE, -Q_ONE, 0, Q_ONE, 0, 0), 1'b0, '0);
		// One-LSB gains: products land on or just beside the rounding halfway point.
		add_row(3, mk_sample(0, 0, 0, 0, HALF_LSB, 0, 0, 0), 1'b0, '0);
		add_row(3, mk_sample(0, 0, 0, 0, -HALF_LSB, 0, 0, 0), 1'b0, '0);
		add_row(3, mk_sample(0, 0, 0, -HALF_LSB - 1, 0, 0, 0, 0), 1'b0, '0);
		add_row(3, mk_sample(0, 0, 0, 0, HALF_LSB - 1, HALF_LSB, 0, 0), 1'b0, '0);
		// Mixed gains with moderate and full-scale references.
		add_row(4, mk_sample(Q_ONE, -Q_ONE, 32'sh3_8000, -32'sh1_4000, 32'sh0_C000,
			32'sh2_0000, 32'sh5_0000, -32'sh7_0000), 1'b0, '0);
		add_row(4, mk_sample(Q_MIN, Q_MIN, -Q_ONE, -Q_ONE, -Q_ONE, -Q_ONE, 0, 0),
			1'b0, '0);
		add_row(4, mk_sample(Q_MAX, Q_MAX, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0),
			1'b0, '0);

		burst_left = $urandom_range(1, 12);
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: reload the gains whenever the row's setting changes.
		cur_set = 0;
		for (int n = 0; n < dir_q.size(); n++) begin
			if (dir_q[n].gsel != cur_set) begin
				wait_idle();
				cur_set = dir_q[n].gsel;
				load_gain_set(cur_set);
			end
			send_sample(dir_q[n].smp, dir_q[n].pinned, dir_q[n].res);
		end

		// Random phases, each with a fresh gain setting.
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == NUM_PHASES - 1)
				mode = 2;
			else begin
				mode = $urandom_range(0, 5);
				mode = (mode <= 3) ? 0 : mode - 3;
			end
			for (int i = 0; i < NUM_REGS; i++)
				gain_sets[RAND_SET][i] = rand_gain(mode);
			wait_idle();
			load_gain_set(RAND_SET);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_sample(mk_sample(rand_q(), rand_q(), rand_q(), rand_q(),
					rand_q(), rand_q(), rand_q(), rand_q()), 1'b0, '0);
		end

		// Drain, then watch a little longer for stray strobes.
		wait_idle();
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (fault_count == 0 && torque_due.size() == 0)
			$display("computed_torque_base_control_unit: match");
		else
			$display("computed_torque_base_control_unit: mismatch");
		$finish;
	end

endmodule

FILE: computed_torque_base_control_unit.f
hdl/ctbc_pkg.sv
hdl/ctbc_lane.sv
hdl/ctbc_merge.sv
hdl/computed_torque_base_control_unit.sv
dv/computed_torque_base_control_unit_tb.sv
